[rtl/spct_pkg.sv]
// Shared types, constants and field layout for the shape pair contact tracker.
// Used by every module of the block except spct_ram; depends on nothing.
`default_nettype none

package spct_pkg;

	localparam int MAX_OBJECTS = 64;
	localparam int COORD_BITS  = 16;
	localparam int IDX_W       = $clog2(MAX_OBJECTS);
	localparam int SIZE_BITS   = COORD_BITS - 1;
	localparam int EXT_W       = COORD_BITS + 1;
	localparam int DIFF_W      = COORD_BITS;
	localparam int RAD_W       = COORD_BITS;
	localparam int SQ_W        = 2 * COORD_BITS;
	localparam int SUM_W       = SQ_W + 1;
	localparam int QDEPTH      = 4;

	localparam int OFF_IDX_A = 0;
	localparam int OFF_IDX_B = OFF_IDX_A + IDX_W;
	localparam int OFF_PXA   = OFF_IDX_B + IDX_W;
	localparam int OFF_PYA   = OFF_PXA + COORD_BITS;
	localparam int OFF_WA    = OFF_PYA + COORD_BITS;
	localparam int OFF_HA    = OFF_WA + SIZE_BITS;
	localparam int OFF_PXB   = OFF_HA + SIZE_BITS;
	localparam int OFF_PYB   = OFF_PXB + COORD_BITS;
	localparam int OFF_WB    = OFF_PYB + COORD_BITS;
	localparam int OFF_HB    = OFF_WB + SIZE_BITS;
	localparam int IN_FIELD_W  = OFF_HB + SIZE_BITS;
	localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
	localparam int KIND_W      = 2;
	localparam int IN_TUSER_W  = 2 * KIND_W;
	localparam int OUT_FIELD_W = 3;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_RECT   = 2'd0,
		KIND_CIRCLE = 2'd1,
		KIND_OTHER  = 2'd2,
		KIND_OFF    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_BEGIN = 2'd1,
		EV_END   = 2'd2,
		EV_SKIP  = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		MODE_SKIP,
		MODE_NONE,
		MODE_RR,
		MODE_CC,
		MODE_CR
	} mode_t;

	typedef struct packed {
		logic             skip;
		logic             hit;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} pair_res_t;

endpackage

`default_nettype wire

[rtl/spct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module spct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/spct_front.sv]
// Front end: accepts shape pairs, classifies them and runs the overlap geometry pipeline.
// Depends on spct_pkg.
`default_nettype none

module spct_front (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire [spct_pkg::IN_TDATA_W-1:0]    in_data,
	input  wire [spct_pkg::IN_TUSER_W-1:0]    in_user,
	output logic                              res_valid,
	input  wire                               res_ready,
	output spct_pkg::pair_res_t               res
);

	localparam int C  = spct_pkg::COORD_BITS;
	localparam int S  = spct_pkg::SIZE_BITS;
	localparam int E  = spct_pkg::EXT_W;
	localparam int IW = spct_pkg::IDX_W;

	spct_pkg::kind_t kind_a, kind_b;
	spct_pkg::mode_t mode_in;
	logic            swap;
	logic [IW-1:0]   idx_a, idx_b;
	logic            adv;

	logic            v_s1, v_s2, v_s3;
	spct_pkg::mode_t mode_s1, mode_s2, mode_s3;
	logic [C-1:0]    p_x_s1, p_y_s1, q_x_s1, q_y_s1;
	logic [S-1:0]    p_w_s1, p_h_s1, q_w_s1, q_h_s1;
	logic [IW-1:0]   row_s1, col_s1, row_s2, col_s2, row_s3, col_s3;

	logic signed [E-1:0] px_e, py_e, qx_e, qy_e, pw_e, ph_e, qw_e, qh_e;
	logic signed [E-1:0] pr_e, pb_e, qr_e, qb_e, cl_x, cl_y, sub_x, sub_y, dx, dy;
	logic                rr_hit;
	logic [spct_pkg::DIFF_W-1:0] dxa, dya;
	logic [spct_pkg::RAD_W-1:0]  rad;

	logic                        rr_hit_s2, rr_hit_s3;
	logic [spct_pkg::DIFF_W-1:0] dxa_s2, dya_s2;
	logic [spct_pkg::RAD_W-1:0]  rad_s2;
	logic [spct_pkg::SQ_W-1:0]   dx2_s3, dy2_s3, r2_s3;
	logic [spct_pkg::SUM_W-1:0]  dist2;
	logic                        round_hit;

	assign kind_a = spct_pkg::kind_t'(in_user[spct_pkg::KIND_W-1:0]);
	assign kind_b = spct_pkg::kind_t'(in_user[2*spct_pkg::KIND_W-1:spct_pkg::KIND_W]);
	assign idx_a  = in_data[spct_pkg::OFF_IDX_A +: IW];
	assign idx_b  = in_data[spct_pkg::OFF_IDX_B +: IW];
	assign swap   = (kind_a == spct_pkg::KIND_RECT) && (kind_b == spct_pkg::KIND_CIRCLE);

	always_comb begin
		priority if (kind_a == spct_pkg::KIND_OFF || kind_b == spct_pkg::KIND_OFF) begin
			mode_in = spct_pkg::MODE_SKIP;
		end else if (kind_a == spct_pkg::KIND_RECT && kind_b == spct_pkg::KIND_RECT) begin
			mode_in = spct_pkg::MODE_RR;
		end else if (kind_a == spct_pkg::KIND_CIRCLE && kind_b == spct_pkg::KIND_CIRCLE) begin
			mode_in = spct_pkg::MODE_CC;
		end else if (swap || (kind_a == spct_pkg::KIND_CIRCLE && kind_b == spct_pkg::KIND_RECT)) begin
			mode_in = spct_pkg::MODE_CR;
		end else begin
			mode_in = spct_pkg::MODE_NONE;
		end
	end

	// stall the whole pipe only when the last stage cannot drain
	assign adv       = !v_s3 || res_ready;
	assign in_ready  = adv;
	assign res_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: input capture, circle first for mixed pairs
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode_in;
			row_s1  <= (idx_a < idx_b) ? idx_a : idx_b;
			col_s1  <= (idx_a < idx_b) ? idx_b : idx_a;
			if (swap) begin
				p_x_s1 <= in_data[spct_pkg::OFF_PXB +: C];
				p_y_s1 <= in_data[spct_pkg::OFF_PYB +: C];
				p_w_s1 <= in_data[spct_pkg::OFF_WB +: S];
				p_h_s1 <= in_data[spct_pkg::OFF_HB +: S];
				q_x_s1 <= in_data[spct_pkg::OFF_PXA +: C];
				q_y_s1 <= in_data[spct_pkg::OFF_PYA +: C];
				q_w_s1 <= in_data[spct_pkg::OFF_WA +: S];
				q_h_s1 <= in_data[spct_pkg::OFF_HA +: S];
			end else begin
				p_x_s1 <= in_data[spct_pkg::OFF_PXA +: C];
				p_y_s1 <= in_data[spct_pkg::OFF_PYA +: C];
				p_w_s1 <= in_data[spct_pkg::OFF_WA +: S];
				p_h_s1 <= in_data[spct_pkg::OFF_HA +: S];
				q_x_s1 <= in_data[spct_pkg::OFF_PXB +: C];
				q_y_s1 <= in_data[spct_pkg::OFF_PYB +: C];
				q_w_s1 <= in_data[spct_pkg::OFF_WB +: S];
				q_h_s1 <= in_data[spct_pkg::OFF_HB +: S];
			end
		end
	end

	// stage 2: edges, clamp, differences
	always_comb begin
		px_e  = {p_x_s1[C-1], p_x_s1};
		py_e  = {p_y_s1[C-1], p_y_s1};
		qx_e  = {q_x_s1[C-1], q_x_s1};
		qy_e  = {q_y_s1[C-1], q_y_s1};
		pw_e  = {{(E-S){1'b0}}, p_w_s1};
		ph_e  = {{(E-S){1'b0}}, p_h_s1};
		qw_e  = {{(E-S){1'b0}}, q_w_s1};
		qh_e  = {{(E-S){1'b0}}, q_h_s1};
		pr_e  = px_e + pw_e;
		pb_e  = py_e + ph_e;
		qr_e  = qx_e + qw_e;
		qb_e  = qy_e + qh_e;
		rr_hit = (px_e < qr_e) && (pr_e > qx_e) && (py_e < qb_e) && (pb_e > qy_e);
		cl_x  = (px_e < qx_e) ? qx_e : ((px_e > qr_e) ? qr_e : px_e);
		cl_y  = (py_e < qy_e) ? qy_e : ((py_e > qb_e) ? qb_e : py_e);
		sub_x = (mode_s1 == spct_pkg::MODE_CR) ? cl_x : qx_e;
		sub_y = (mode_s1 == spct_pkg::MODE_CR) ? cl_y : qy_e;
		dx    = px_e - sub_x;
		dy    = py_e - sub_y;
		dxa   = dx[E-1] ? spct_pkg::DIFF_W'(-dx) : spct_pkg::DIFF_W'(dx);
		dya   = dy[E-1] ? spct_pkg::DIFF_W'(-dy) : spct_pkg::DIFF_W'(dy);
		rad   = (mode_s1 == spct_pkg::MODE_CC)
			? spct_pkg::RAD_W'(p_w_s1) + spct_pkg::RAD_W'(q_w_s1)
			: spct_pkg::RAD_W'(p_w_s1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2   <= mode_s1;
			row_s2    <= row_s1;
			col_s2    <= col_s1;
			rr_hit_s2 <= rr_hit;
			dxa_s2    <= dxa;
			dya_s2    <= dya;
			rad_s2    <= rad;
		end
	end

	// stage 3: squares
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s3   <= mode_s2;
			row_s3    <= row_s2;
			col_s3    <= col_s2;
			rr_hit_s3 <= rr_hit_s2;
			dx2_s3    <= spct_pkg::SQ_W'(dxa_s2) * spct_pkg::SQ_W'(dxa_s2);
			dy2_s3    <= spct_pkg::SQ_W'(dya_s2) * spct_pkg::SQ_W'(dya_s2);
			r2_s3     <= spct_pkg::SQ_W'(rad_s2) * spct_pkg::SQ_W'(rad_s2);
		end
	end

	assign dist2     = spct_pkg::SUM_W'(dx2_s3) + spct_pkg::SUM_W'(dy2_s3);
	assign round_hit = dist2 <= spct_pkg::SUM_W'(r2_s3);

	always_comb begin
		res.row  = row_s3;
		res.col  = col_s3;
		res.skip = 1'b0;
		unique case (mode_s3)
			spct_pkg::MODE_SKIP: begin
				res.skip = 1'b1;
				res.hit  = 1'b0;
			end
			spct_pkg::MODE_RR:   res.hit = rr_hit_s3;
			spct_pkg::MODE_CC,
			spct_pkg::MODE_CR:   res.hit = round_hit;
			default:             res.hit = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/spct_queue.sv]
// Short FIFO of classified pair results between the front and back ends.
// Depends on spct_pkg.
`default_nettype none

module spct_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push_valid,
	output logic                push_ready,
	input  spct_pkg::pair_res_t push_data,
	output logic                pop_valid,
	input  wire                 pop_ready,
	output spct_pkg::pair_res_t pop_data
);

	localparam int PW = $clog2(spct_pkg::QDEPTH);
	localparam int CW = $clog2(spct_pkg::QDEPTH + 1);

	spct_pkg::pair_res_t entry_q [spct_pkg::QDEPTH];
	logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]       cnt_q;
	logic                do_push, do_pop;

	assign push_ready = cnt_q != CW'(spct_pkg::QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(spct_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(spct_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[rtl/spct_back.sv]
// Back end: contact matrix read-modify-write, event coding and output register.
// Depends on spct_pkg and spct_ram.
`default_nettype none

module spct_back (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                pop_valid,
	output logic                               pop_ready,
	input  spct_pkg::pair_res_t                pop_data,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [spct_pkg::OUT_TDATA_W-1:0]   out_data
);

	localparam int N  = spct_pkg::MAX_OBJECTS;
	localparam int IW = spct_pkg::IDX_W;

	logic                v_s1;
	spct_pkg::pair_res_t ent_s1;
	logic                s1_adv, pop, wr_en, was;
	logic [N-1:0]        ram_q, cur_row, new_row;
	logic [N-1:0]        row_vld_q;
	logic                fwd_v_q;
	logic [IW-1:0]       fwd_row_q;
	logic [N-1:0]        fwd_data_q;
	logic                out_v_q, out_ov_q;
	spct_pkg::event_t    out_ev_q, ev;

	assign s1_adv    = v_s1 && (!out_v_q || out_ready);
	assign pop       = pop_valid && (!v_s1 || s1_adv);
	assign pop_ready = !v_s1 || s1_adv;
	assign wr_en     = s1_adv && !ent_s1.skip;

	spct_ram #(
		.WIDTH(N),
		.DEPTH(N)
	) u_matrix (
		.clk  (clk),
		.we   (wr_en),
		.waddr(ent_s1.row),
		.wdata(new_row),
		.re   (pop),
		.raddr(pop_data.row),
		.rdata(ram_q)
	);

	// forward a row written at the same edge it was read
	always_comb begin
		if (fwd_v_q && fwd_row_q == ent_s1.row) begin
			cur_row = fwd_data_q;
		end else if (row_vld_q[ent_s1.row]) begin
			cur_row = ram_q;
		end else begin
			cur_row = '0;
		end
		was              = cur_row[ent_s1.col];
		new_row          = cur_row;
		new_row[ent_s1.col] = ent_s1.hit;
		priority if (ent_s1.skip) begin
			ev = spct_pkg::EV_SKIP;
		end else if (ent_s1.hit && !was) begin
			ev = spct_pkg::EV_BEGIN;
		end else if (!ent_s1.hit && was) begin
			ev = spct_pkg::EV_END;
		end else begin
			ev = spct_pkg::EV_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_v_q   <= 1'b0;
			row_vld_q <= '0;
			fwd_v_q   <= 1'b0;
		end else begin
			if (pop) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (wr_en) begin
				row_vld_q[ent_s1.row] <= 1'b1;
			end
			if (pop) begin
				fwd_v_q <= wr_en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s1     <= pop_data;
			fwd_row_q  <= ent_s1.row;
			fwd_data_q <= new_row;
		end
		if (s1_adv) begin
			out_ov_q <= ent_s1.hit && !ent_s1.skip;
			out_ev_q <= ev;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = {{(spct_pkg::OUT_TDATA_W - spct_pkg::OUT_FIELD_W){1'b0}}, out_ev_q, out_ov_q};

endmodule

`default_nettype wire

[rtl/shape_pair_contact_tracker.sv]
// Shape pair contact tracker: overlap test of 2D shape pairs with contact enter/exit events.
// Top level; depends on spct_pkg, spct_front, spct_queue and spct_back.
//
// Input channel s_axis: one transaction is one pair of shapes (slot numbers, kinds in
// s_axis_tuser, positions Q12.4 and sizes Q11.4 in s_axis_tdata). Output channel m_axis:
// one transaction per input pair, carrying overlap_now and contact_event, in input order.
// Throughput: one pair per clock, sustained, as long as m_axis_tready stays high.
// Each input passes three geometry stages, one queue slot and one matrix read-modify-write
// stage feeding the output register before its result is presented on m_axis. The contact
// matrix is a 64 x 64 bit RAM holding one row per lower slot number, read once per pair
// and written once per pair that is not skipped; per-row valid flops make it read as all
// zero after reset, so there is no clearing pass and s_axis_tready rises right after
// reset. When the receiver stalls, the output register holds, the back end stops, the
// four-entry queue fills, and then the geometry pipe freezes and s_axis_tready drops.
// Reset (arst_n low) empties every stage and the queue and forgets all contacts.
`default_nettype none

module shape_pair_contact_tracker (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// index_a, index_b, pos_x_a, pos_y_a, size_w_a, size_h_a,
	// pos_x_b, pos_y_b, size_w_b, size_h_b
	input  wire [spct_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// kind_a, kind_b
	input  wire [spct_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// overlap_now, contact_event, zero padding
	output logic [spct_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	logic                res_valid, res_ready, pop_valid, pop_ready;
	spct_pkg::pair_res_t res, pop_data;

	spct_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	spct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(res_valid),
		.push_ready(res_ready),
		.push_data (res),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	spct_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata)
	);

endmodule

`default_nettype wire

[rtl/spct_checker.sv]
// Port-level assertions for the shape pair contact tracker, bound to the top level.
// Depends on spct_pkg and shape_pair_contact_tracker.
`default_nettype none

module spct_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              m_axis_tvalid,
	input wire                              m_axis_tready,
	input wire [spct_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	logic       ov;
	logic [1:0] ev;

	assign ov = m_axis_tdata[0];
	assign ev = m_axis_tdata[2:1];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			m_axis_tdata[spct_pkg::OUT_TDATA_W-1:spct_pkg::OUT_FIELD_W] == '0)
		else $error("output padding not zero");

	a_event_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(ev == spct_pkg::EV_NONE) ||
			(ev == spct_pkg::EV_BEGIN && ov) ||
			(ev == spct_pkg::EV_END && !ov) ||
			(ev == spct_pkg::EV_SKIP && !ov))
		else $error("contact event disagrees with overlap");

endmodule

bind shape_pair_contact_tracker spct_checker u_spct_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
